[design/fvdsa_pkg.sv]
// Shared types and constants of the finite-volume diffusion stencil assembler.
package fvdsa_pkg;

    // Fixed-point formats of the widths, the viscosity and the coefficient.
    localparam int WIDTH_W   = 32;
    localparam int FRAC_BITS = 24;
    localparam int COEF_W    = 48;
    localparam int OFFSET_W  = 22;

    // Divider formats: 97-bit dividend, 57-bit divisor, 48 quotient bits.
    localparam int NUM_W  = 97;
    localparam int DEN_W  = 57;
    localparam int QUOT_W = 48;
    localparam int CNT_W  = 6;
    localparam logic [QUOT_W-1:0] MAG_LIMIT = {1'b1, {(QUOT_W-1){1'b0}}};
    localparam logic [COEF_W-1:0] S48_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] S48_MIN   = {1'b1, {(COEF_W-1){1'b0}}};

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_THREE_D  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VISC     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET   = 2'd2;
    localparam logic [WIDTH_W-1:0]   VISC_RESET   = 32'h0100_0000;

    // Face codes; the first pair is y normal in 2D and z normal in 3D.
    localparam logic [2:0] FACE_ZN_LO = 3'd0;
    localparam logic [2:0] FACE_XN_LO = 3'd1;
    localparam logic [2:0] FACE_ZN_HI = 3'd2;
    localparam logic [2:0] FACE_XN_HI = 3'd3;
    localparam logic [2:0] FACE_YN_LO = 3'd4;
    localparam logic [2:0] FACE_YN_HI = 3'd5;

    // Status codes of a result word.
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_ZERO_DEN = 2'd1,
        STATUS_BAD_FACE = 2'd2
    } status_t;

    // Sequencer states.
    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_MUL_AREA  = 8'b0000_0010,
        ST_MUL_LO    = 8'b0000_0100,
        ST_MUL_HI    = 8'b0000_1000,
        ST_SUM       = 8'b0001_0000,
        ST_DIV_GO    = 8'b0010_0000,
        ST_DIV_WAIT  = 8'b0100_0000,
        ST_EMIT_FACE = 8'b1000_0000
    } state_t;

    // Request to the divider.
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    // Response of the divider.
    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] mag;
    } div_rsp_t;

endpackage

[design/fvdsa_divider.sv]
// Bit-serial restoring divider that returns a quotient magnitude clamped at 2^47.
module fvdsa_divider
(
    input  logic                clk,
    input  logic                rst_n,
    input  fvdsa_pkg::div_req_t req,
    output fvdsa_pkg::div_rsp_t rsp
);
    import fvdsa_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [QUOT_W-1:0] low_reg;
    logic [QUOT_W-1:0] quot_reg;

    logic [NUM_W-QUOT_W-1:0] num_hi;
    logic                    overflow;
    logic [DEN_W:0]          trial;
    logic                    fits;

    // A dividend whose upper part already reaches the divisor gives a quotient
    // of at least 2^48, which clamps at once.
    assign num_hi   = req.num[NUM_W-1:QUOT_W];
    assign overflow = DEN_W'(num_hi) >= req.den;

    // One quotient bit per cycle.
    assign trial = {rem_reg, low_reg[QUOT_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= !overflow;
                done_reg <= overflow;
                cnt_reg  <= CNT_W'(QUOT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Partial remainder, dividend bits and quotient.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            den_reg  <= req.den;
            rem_reg  <= DEN_W'(num_hi);
            low_reg  <= req.num[QUOT_W-1:0];
            quot_reg <= overflow ? MAG_LIMIT : '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            low_reg  <= {low_reg[QUOT_W-2:0], 1'b0};
            quot_reg <= {quot_reg[QUOT_W-2:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.mag  = (quot_reg > MAG_LIMIT) ? MAG_LIMIT : quot_reg;

endmodule

[design/fv_diffusion_stencil_assembler_top.sv]
// Top level of the finite-volume diffusion stencil assembler.
//
// Each input word on the s_ side is one face of an interior cell; s_tlast
// marks the cell's last face. For every face the block returns one
// (row, column, coefficient) word on the m_ side with the status in m_tuser.
// After the last face of a cell a second word follows: the diagonal entry,
// minus the sum of the cell's face coefficients, with m_tlast high.
// A legal face goes from acceptance to its result word by way of three
// passes through the one 32x32 multiplier, one dividend add, the divider
// start and 48 steps of the bit-serial divider, one quotient bit per cycle.
// A quotient that clamps at once skips the steps. A face with an illegal
// code or a zero denominator goes from acceptance straight to the emit step.
// s_tready is high only while the sequencer is idle, so a new face is not
// accepted before the previous face has passed the emit step, nor before
// a pending diagonal word has been loaded. The next face can be accepted
// while the previous result still waits in the output register.
// When the receiver stalls, the sequencer holds in its emit step until the
// output register is free. Reset clears the face sum and sets the registers
// to 2D, viscosity 1.0 and offset 0. Configuration writes on cfg_wr_en are
// taken at once and must happen only while the block is idle.
module fv_diffusion_stencil_assembler_top
#(
    parameter int INDEX_BITS = 20
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port.
    input  logic                                cfg_wr_en,
    input  logic [fvdsa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fvdsa_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Face words in.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // cell_index, face_number, neighbor_number, cell_width_x, cell_width_y,
    // cell_width_z, neighbor_normal_width, zero pad
    input  logic [((2*INDEX_BITS+132+7)/8)*8-1:0] s_tdata,
    input  logic                                s_tlast,     // last_face
    // Matrix entry words out.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // row, column, coefficient, zero pad
    output logic [((2*INDEX_BITS+52+7)/8)*8-1:0]  m_tdata,
    output logic [1:0]                          m_tuser,     // status
    output logic                                m_tlast      // last
);
    import fvdsa_pkg::*;

    localparam int NBR_W       = INDEX_BITS + 1;
    localparam int OUT_W       = INDEX_BITS + 2;
    localparam int OUT_DATA_W  = ((2*INDEX_BITS+52+7)/8)*8;
    localparam int FACE_LSB    = INDEX_BITS;
    localparam int NBR_LSB     = FACE_LSB + 3;
    localparam int WX_LSB      = NBR_LSB + NBR_W;
    localparam int WY_LSB      = WX_LSB + WIDTH_W;
    localparam int WZ_LSB      = WY_LSB + WIDTH_W;
    localparam int NW_LSB      = WZ_LSB + WIDTH_W;
    localparam int COEF_LSB    = 2*OUT_W;

    // Registers and sequencer state.
    state_t                state_reg, state_next;
    logic                  diag_pend_reg, diag_pend_next;
    logic                  three_d_reg;
    logic [WIDTH_W-1:0]    visc_reg;
    logic [OFFSET_W-1:0]   offset_reg;
    logic [COEF_W-1:0]     face_sum_reg, face_sum_next;
    logic                  m_tvalid_reg, m_tvalid_next;

    // Per-item payload.
    logic [WIDTH_W-1:0]    a1_reg, a2_reg;
    logic [WIDTH_W:0]      den_reg;
    logic [OUT_W-1:0]      row_reg, col_reg;
    status_t               status_reg;
    logic                  last_face_reg;
    logic [2*WIDTH_W-1:0]  area_reg, p0_reg, p1_reg;
    logic [NUM_W-1:0]      num_reg;
    logic [QUOT_W-1:0]     mag_reg;

    // Output register.
    logic [OUT_W-1:0]      out_row_reg, out_col_reg;
    logic [COEF_W-1:0]     out_coef_reg;
    status_t               out_status_reg;
    logic                  out_last_reg;

    // Input fields.
    logic [INDEX_BITS-1:0] in_cell;
    logic [2:0]            in_face;
    logic [NBR_W-1:0]      in_nbr;
    logic [WIDTH_W-1:0]    in_wx, in_wy, in_wz, in_nw;

    logic [WIDTH_W-1:0]    dec_a1, dec_a2, dec_cw;
    logic [WIDTH_W:0]      dec_den;
    logic                  dec_bad;
    status_t               dec_status;

    logic                  in_fire, out_free, load_face, load_diag;
    logic [WIDTH_W-1:0]    mul_a, mul_b;
    logic [2*WIDTH_W-1:0]  mul_p;
    logic [NUM_W-2:0]      prod_sum;
    logic [COEF_W-1:0]     coef_face, diag_coef, sat_sum;
    logic [COEF_W:0]       sum_wide;
    div_req_t              div_req;
    div_rsp_t              div_rsp;

    assign in_cell = s_tdata[INDEX_BITS-1:0];
    assign in_face = s_tdata[FACE_LSB +: 3];
    assign in_nbr  = s_tdata[NBR_LSB +: NBR_W];
    assign in_wx   = s_tdata[WX_LSB +: WIDTH_W];
    assign in_wy   = s_tdata[WY_LSB +: WIDTH_W];
    assign in_wz   = s_tdata[WZ_LSB +: WIDTH_W];
    assign in_nw   = s_tdata[NW_LSB +: WIDTH_W];

    // Face decode: area factors, the cell's own normal width and the status.
    always_comb
    begin
        dec_a1  = '0;
        dec_a2  = WIDTH_W'(1);
        dec_cw  = '0;
        dec_bad = 1'b0;
        case (in_face)
            FACE_ZN_LO, FACE_ZN_HI:
            begin
                dec_a1 = in_wx;
                dec_a2 = three_d_reg ? in_wy : WIDTH_W'(1);
                dec_cw = three_d_reg ? in_wz : in_wy;
            end
            FACE_XN_LO, FACE_XN_HI:
            begin
                dec_a1 = in_wy;
                dec_a2 = three_d_reg ? in_wz : WIDTH_W'(1);
                dec_cw = in_wx;
            end
            FACE_YN_LO, FACE_YN_HI:
            begin
                dec_a1  = in_wx;
                dec_a2  = in_wz;
                dec_cw  = in_wy;
                dec_bad = !three_d_reg;
            end
            default:
            begin
                dec_bad = 1'b1;
            end
        endcase
        dec_den = {1'b0, in_nw} + {1'b0, dec_cw};
        if (dec_bad)
            dec_status = STATUS_BAD_FACE;
        else if (dec_den == '0)
            dec_status = STATUS_ZERO_DEN;
        else
            dec_status = STATUS_OK;
    end

    assign s_tready = (state_reg == ST_IDLE) && !diag_pend_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Shared 32x32 multiplier: area first, then the two viscosity products.
    always_comb
    begin
        case (state_reg)
            ST_MUL_AREA:
            begin
                mul_a = a1_reg;
                mul_b = a2_reg;
            end
            ST_MUL_LO:
            begin
                mul_a = visc_reg;
                mul_b = area_reg[WIDTH_W-1:0];
            end
            ST_MUL_HI:
            begin
                mul_a = visc_reg;
                mul_b = area_reg[2*WIDTH_W-1:WIDTH_W];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p    = mul_a * mul_b;
    assign prod_sum = (NUM_W-1)'({p1_reg, {WIDTH_W{1'b0}}}) + (NUM_W-1)'(p0_reg);

    // Divider request; in 3D the denominator carries the extra width factor.
    assign div_req.start = (state_reg == ST_DIV_GO);
    assign div_req.num   = num_reg;
    assign div_req.den   = three_d_reg ? DEN_W'({den_reg, {FRAC_BITS{1'b0}}})
                                       : DEN_W'(den_reg);

    fvdsa_divider u_divider
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Face coefficient, saturating face sum and diagonal value.
    assign coef_face = (status_reg == STATUS_OK) ? (COEF_W'(0) - mag_reg) : '0;
    assign sum_wide  = {face_sum_reg[COEF_W-1], face_sum_reg}
                     + {coef_face[COEF_W-1], coef_face};
    always_comb
    begin
        if (sum_wide[COEF_W] != sum_wide[COEF_W-1])
            sat_sum = sum_wide[COEF_W] ? S48_MIN : S48_MAX;
        else
            sat_sum = sum_wide[COEF_W-1:0];
    end
    assign diag_coef = (face_sum_reg == S48_MIN) ? S48_MAX : (COEF_W'(0) - face_sum_reg);

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        diag_pend_next = diag_pend_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        face_sum_next  = face_sum_reg;
        load_face      = 1'b0;
        load_diag      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (diag_pend_reg)
                begin
                    if (out_free)
                    begin
                        load_diag      = 1'b1;
                        m_tvalid_next  = 1'b1;
                        face_sum_next  = '0;
                        diag_pend_next = 1'b0;
                    end
                end
                else if (s_tvalid)
                begin
                    state_next = (dec_status == STATUS_OK) ? ST_MUL_AREA : ST_EMIT_FACE;
                end
            end
            ST_MUL_AREA: state_next = ST_MUL_LO;
            ST_MUL_LO:   state_next = ST_MUL_HI;
            ST_MUL_HI:   state_next = ST_SUM;
            ST_SUM:      state_next = ST_DIV_GO;
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                    state_next = ST_EMIT_FACE;
            end
            ST_EMIT_FACE:
            begin
                if (out_free)
                begin
                    load_face      = 1'b1;
                    m_tvalid_next  = 1'b1;
                    face_sum_next  = (status_reg == STATUS_OK) ? sat_sum : face_sum_reg;
                    diag_pend_next = last_face_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            diag_pend_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            face_sum_reg  <= '0;
            three_d_reg   <= 1'b0;
            visc_reg      <= VISC_RESET;
            offset_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            diag_pend_reg <= diag_pend_next;
            m_tvalid_reg  <= m_tvalid_next;
            face_sum_reg  <= face_sum_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_THREE_D: three_d_reg <= cfg_data[0];
                    REG_VISC:    visc_reg    <= cfg_data[WIDTH_W-1:0];
                    REG_OFFSET:  offset_reg  <= cfg_data[OFFSET_W-1:0];
                    default:     ;
                endcase
            end
        end
    end

    // Item payload and arithmetic results.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a1_reg        <= dec_a1;
            a2_reg        <= dec_a2;
            den_reg       <= dec_den;
            status_reg    <= dec_status;
            last_face_reg <= s_tlast;
            row_reg       <= OUT_W'(in_cell) + OUT_W'(offset_reg);
            col_reg       <= OUT_W'(in_nbr) + OUT_W'(offset_reg) - OUT_W'(1);
        end
        if (state_reg == ST_MUL_AREA)
            area_reg <= mul_p;
        if (state_reg == ST_MUL_LO)
            p0_reg <= mul_p;
        if (state_reg == ST_MUL_HI)
            p1_reg <= mul_p;
        if (state_reg == ST_SUM)
            num_reg <= {prod_sum, 1'b0};
        if (state_reg == ST_DIV_WAIT && div_rsp.done)
            mag_reg <= div_rsp.mag;
        if (in_fire && dec_status != STATUS_OK)
            mag_reg <= '0;
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (load_face)
        begin
            out_row_reg    <= row_reg;
            out_col_reg    <= col_reg;
            out_coef_reg   <= coef_face;
            out_status_reg <= status_reg;
            out_last_reg   <= !last_face_reg;
        end
        else if (load_diag)
        begin
            out_row_reg    <= row_reg;
            out_col_reg    <= row_reg;
            out_coef_reg   <= diag_coef;
            out_status_reg <= STATUS_OK;
            out_last_reg   <= 1'b1;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_DATA_W'({out_coef_reg, out_col_reg, out_row_reg});
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    // The divider finishes only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == ST_DIV_WAIT)
        else $error("divider finished outside the wait step");

    // A diagonal word leaves the sum cleared and carries status ok and last.
    assert property (@(posedge clk) disable iff (!rst_n)
        load_diag |=> face_sum_reg == '0 && m_tvalid && m_tlast && m_tuser == STATUS_OK)
        else $error("diagonal word or sum clear is wrong");

    // An error word carries a zero coefficient.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != STATUS_OK) |-> m_tdata[COEF_LSB +: COEF_W] == '0)
        else $error("error word with nonzero coefficient");

endmodule

[verif/fvdsa_stencil_checker.sv]
// Stencil entry checker: predicts the matrix entry words from the face words and compares them.
module fvdsa_stencil_checker
#(
    parameter int INDEX_BITS = 20
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [fvdsa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fvdsa_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                  s_tvalid,
    input  logic                                  s_tready,
    input  logic [((2*INDEX_BITS+132+7)/8)*8-1:0] s_tdata,
    input  logic                                  s_tlast,
    input  logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic [((2*INDEX_BITS+52+7)/8)*8-1:0]  m_tdata,
    input  logic [1:0]                            m_tuser,
    input  logic                                  m_tlast,
    output int                                    mismatch_count,
    output int                                    entries_pending
);

    import fvdsa_pkg::*;

    localparam int S_W      = ((2*INDEX_BITS+132+7)/8)*8;
    localparam int ROW_W    = INDEX_BITS + 2;
    localparam int NBR_W    = INDEX_BITS + 1;
    localparam int FACE_LSB = INDEX_BITS;
    localparam int NBR_LSB  = INDEX_BITS + 3;
    localparam int WX_LSB   = 2*INDEX_BITS + 4;
    localparam int WY_LSB   = WX_LSB + WIDTH_W;
    localparam int WZ_LSB   = WY_LSB + WIDTH_W;
    localparam int NW_LSB   = WZ_LSB + WIDTH_W;
    localparam int COL_LSB  = ROW_W;
    localparam int COEF_LSB = 2*ROW_W;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [ROW_W-1:0]  column;
        logic [COEF_W-1:0] coefficient;
        status_t           status;
        logic              last;
    } entry_t;

    // Local copy of the registers and of the running face sum.
    logic                     three_d;
    logic [WIDTH_W-1:0]       visc;
    logic [OFFSET_W-1:0]      offset;
    logic signed [COEF_W-1:0] face_sum;

    entry_t expected_entries[$];
    int     mismatches;

    // Clamp a widened sum to the signed 48-bit range.
    function automatic logic [COEF_W-1:0] saturate_coef(input logic signed [COEF_W+1:0] v);
        if (v > $signed({2'b00, S48_MAX}))
            return S48_MAX;
        if (v < $signed({2'b11, S48_MIN}))
            return S48_MIN;
        return v[COEF_W-1:0];
    endfunction

    // Work out the face entry, and the diagonal entry on a cell's last face.
    task automatic assemble_face(input logic [S_W-1:0] word, input logic last_face);
        logic [INDEX_BITS-1:0]    cell_idx;
        logic [2:0]               face;
        logic [NBR_W-1:0]         nbr;
        logic [WIDTH_W-1:0]       wx, wy, wz, nw, a1, a2, cw;
        logic [WIDTH_W:0]         den;
        logic [63:0]              area;
        logic [127:0]             dividend, quotient;
        logic [COEF_W-1:0]        mag;
        logic signed [COEF_W-1:0] coef;
        logic signed [COEF_W+1:0] wide;
        logic [ROW_W-1:0]         row, col;
        status_t                  status;
        entry_t                   e;

        cell_idx = word[0 +: INDEX_BITS];
        face = word[FACE_LSB +: 3];
        nbr  = word[NBR_LSB +: NBR_W];
        wx   = word[WX_LSB +: WIDTH_W];
        wy   = word[WY_LSB +: WIDTH_W];
        wz   = word[WZ_LSB +: WIDTH_W];
        nw   = word[NW_LSB +: WIDTH_W];
        row  = cell_idx + offset;
        col  = nbr - 1'b1 + offset;
        status = STATUS_OK;
        coef = '0;

        if (face > FACE_YN_HI || (!three_d && face > FACE_XN_HI)) begin
            status = STATUS_BAD_FACE;
        end
        else begin
            // Pick the face area factors and the cell width along the normal.
            case (face)
                FACE_ZN_LO, FACE_ZN_HI:
                begin
                    a1 = wx;
                    a2 = three_d ? wy : 32'd1;
                    cw = three_d ? wz : wy;
                end
                FACE_XN_LO, FACE_XN_HI:
                begin
                    a1 = wy;
                    a2 = three_d ? wz : 32'd1;
                    cw = wx;
                end
                default:
                begin
                    a1 = wx;
                    a2 = wz;
                    cw = wy;
                end
            endcase
            den = {1'b0, nw} + {1'b0, cw};
            if (den == '0) begin
                status = STATUS_ZERO_DEN;
            end
            else begin
                // Exact quotient, magnitude clamped at 2^47, then negated.
                area     = {32'b0, a1} * {32'b0, a2};
                dividend = ({96'b0, visc} * {64'b0, area}) << 1;
                quotient = three_d ? dividend / {71'b0, den, 24'b0}
                                   : dividend / {95'b0, den};
                mag      = (quotient > {80'b0, MAG_LIMIT}) ? MAG_LIMIT
                                                           : quotient[COEF_W-1:0];
                coef     = '0 - mag;
                wide     = face_sum + coef;
                face_sum = saturate_coef(wide);
            end
        end

        e.row         = row;
        e.column      = col;
        e.coefficient = coef;
        e.status      = status;
        e.last        = !last_face;
        expected_entries = {expected_entries, e};

        // The diagonal entry closes the cell and clears the sum.
        if (last_face) begin
            wide          = -face_sum;
            e.column      = row;
            e.coefficient = saturate_coef(wide);
            e.status      = STATUS_OK;
            e.last        = 1'b1;
            expected_entries = {expected_entries, e};
            face_sum = '0;
        end
    endtask

    task automatic compare_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %h, actual %h", name, want, got);
            mismatches++;
        end
    endtask

    // Track register writes, predict on accepted face words, check entry words.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            three_d    = 1'b0;
            visc       = VISC_RESET;
            offset     = '0;
            face_sum   = '0;
            mismatches = 0;
            expected_entries.delete();
            mismatch_count  <= 0;
            entries_pending <= 0;
        end
        else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_THREE_D: three_d = cfg_data[0];
                    REG_VISC:    visc    = cfg_data;
                    REG_OFFSET:  offset  = cfg_data[OFFSET_W-1:0];
                    default:     ;
                endcase
            end

            if (s_tvalid && s_tready)
                assemble_face(s_tdata, s_tlast);

            if (m_tvalid && m_tready) begin
                if (expected_entries.size() == 0) begin
                    $error("entry word with nothing expected: row %h column %h",
                           m_tdata[0 +: ROW_W], m_tdata[COL_LSB +: ROW_W]);
                    mismatches++;
                end
                else begin
                    entry_t e;
                    e = expected_entries.pop_front();
                    compare_field("row", 64'(e.row), 64'(m_tdata[0 +: ROW_W]));
                    compare_field("column", 64'(e.column), 64'(m_tdata[COL_LSB +: ROW_W]));
                    compare_field("coefficient", 64'(e.coefficient),
                                  64'(m_tdata[COEF_LSB +: COEF_W]));
                    compare_field("status", 64'(e.status), 64'(m_tuser));
                    compare_field("last", 64'(e.last), 64'(m_tlast));
                end
            end

            mismatch_count  <= mismatches;
            entries_pending <= expected_entries.size();
        end
    end

endmodule

[verif/tb.sv]
// Testbench top: drives face words and register writes into the stencil assembler.
module tb;

    import fvdsa_pkg::*;

    localparam int INDEX_BITS      = 20;
    localparam int S_W             = ((2*INDEX_BITS+132+7)/8)*8;
    localparam int M_W             = ((2*INDEX_BITS+52+7)/8)*8;
    localparam int RESET_CYCLES    = 7;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 138;
    localparam int HOLD_CYCLES     = 700;
    localparam int TAIL_CYCLES     = 200;
    localparam int CYCLE_LIMIT     = 1000000;

    localparam logic [WIDTH_W-1:0]    ONE_Q24    = 32'h0100_0000;
    localparam logic [OFFSET_W-1:0]   OFFSET_MAX = 22'd3145728;
    localparam logic [INDEX_BITS-1:0] CELL_MAX   = '1;
    localparam logic [INDEX_BITS:0]   NBR_MAX    = '1;
    // Face codes that are never legal.
    localparam logic [2:0] FACE_UNUSED_LO = 3'd6;
    localparam logic [2:0] FACE_UNUSED_HI = 3'd7;

    typedef struct {
        logic [INDEX_BITS-1:0] cell_idx;
        logic [2:0]            face;
        logic [INDEX_BITS:0]   nbr;
        logic [WIDTH_W-1:0]    wx;
        logic [WIDTH_W-1:0]    wy;
        logic [WIDTH_W-1:0]    wz;
        logic [WIDTH_W-1:0]    nw;
        logic                  last;
    } face_word_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_W-1:0]        s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_W-1:0]        m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;

    int   mismatch_count;
    int   entries_pending;
    int   items_sent    = 0;
    logic cur_three_d   = 1'b0;
    logic src_jitter    = 1'b1;
    logic sink_jitter   = 1'b1;
    logic hold_request  = 1'b0;

    fv_diffusion_stencil_assembler_top #(
        .INDEX_BITS (INDEX_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    fvdsa_stencil_checker #(
        .INDEX_BITS (INDEX_BITS)
    ) checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .mismatch_count  (mismatch_count),
        .entries_pending (entries_pending)
    );

    always #5 clk = ~clk;

    // Run limit.
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: random ready bursts and stalls, plus one long hold-off on request.
    initial
    begin : sink
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (sink_jitter && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    function automatic face_word_t face_word(
        input logic [INDEX_BITS-1:0] cell_idx,
        input logic [2:0]            face,
        input logic [INDEX_BITS:0]   nbr,
        input logic [WIDTH_W-1:0]    wx,
        input logic [WIDTH_W-1:0]    wy,
        input logic [WIDTH_W-1:0]    wz,
        input logic [WIDTH_W-1:0]    nw,
        input logic                  last
    );
        face_word_t w;
        w.cell_idx = cell_idx;
        w.face = face;
        w.nbr  = nbr;
        w.wx   = wx;
        w.wy   = wy;
        w.wz   = wz;
        w.nw   = nw;
        w.last = last;
        return w;
    endfunction

    // Widths near 1.0 in four of ten picks, with zeros, maxima, tiny and fully random values mixed in.
    function automatic logic [WIDTH_W-1:0] pick_width();
        case ($urandom_range(0, 9))
            0:          return '0;
            1:          return '1;
            2, 3, 4, 5: return $urandom_range(32'h0040_0000, 32'h0400_0000);
            6:          return $urandom_range(1, 255);
            default:    return $urandom;
        endcase
    endfunction

    // Offer one face word and hold it until accepted, then maybe idle.
    task automatic send_face(input face_word_t w);
        s_tvalid <= 1'b1;
        s_tdata  <= S_W'({w.nw, w.wz, w.wy, w.wx, w.nbr, w.face, w.cell_idx});
        s_tlast  <= w.last;
        do @(posedge clk); while (!s_tready);
        items_sent++;
        if (src_jitter && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    // A complete cell: every face in order, the last one flagged.
    task automatic send_random_cell();
        face_word_t w;
        int         n_faces;
        n_faces    = cur_three_d ? 6 : 4;
        w.cell_idx = INDEX_BITS'($urandom_range(0, CELL_MAX));
        w.wx       = pick_width();
        w.wy       = pick_width();
        w.wz       = pick_width();
        for (int f = 0; f < n_faces; f++) begin
            w.face = 3'(f);
            w.nbr  = (INDEX_BITS+1)'($urandom_range(0, NBR_MAX));
            w.nw   = pick_width();
            w.last = (f == n_faces - 1);
            send_face(w);
        end
    endtask

    // Write all three registers on consecutive cycles.
    task automatic apply_settings(input logic td, input logic [WIDTH_W-1:0] visc,
                                  input logic [OFFSET_W-1:0] off);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_THREE_D;
        cfg_data  <= CFG_DATA_W'(td);
        @(posedge clk);
        cfg_index <= REG_VISC;
        cfg_data  <= visc;
        @(posedge clk);
        cfg_index <= REG_OFFSET;
        cfg_data  <= CFG_DATA_W'(off);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cur_three_d = td;
    endtask

    // Stop offering words and wait until every expected entry has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (entries_pending != 0);
    endtask

    initial
    begin : stimulus
        face_word_t          w;
        int                  target;
        logic                td;
        logic [WIDTH_W-1:0]  visc;
        logic [OFFSET_W-1:0] off;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed 2D cases under the reset settings.
        send_face(face_word(0, FACE_ZN_LO, 1, ONE_Q24, ONE_Q24, 0, ONE_Q24, 1'b0));
        send_face(face_word(0, FACE_XN_LO, 2, ONE_Q24, ONE_Q24, 0, ONE_Q24 >> 1, 1'b0));
        send_face(face_word(0, FACE_ZN_HI, 3, ONE_Q24, ONE_Q24, 0, ONE_Q24 << 2, 1'b0));
        send_face(face_word(0, FACE_XN_HI, 4, ONE_Q24, ONE_Q24, 0, ONE_Q24, 1'b1));
        // A 3D-only face in 2D, with the diagonal following the error.
        send_face(face_word(5, FACE_YN_LO, 6, ONE_Q24, ONE_Q24, ONE_Q24, ONE_Q24, 1'b1));
        // Zero denominator, then a never-legal face code.
        send_face(face_word(7, FACE_ZN_LO, 8, ONE_Q24, 0, 0, 0, 1'b0));
        send_face(face_word(7, FACE_UNUSED_HI, 9, ONE_Q24, ONE_Q24, 0, ONE_Q24, 1'b1));
        // Neighbor number zero wraps the column; all widths at maximum.
        send_face(face_word(CELL_MAX, FACE_XN_LO, 0, '1, '1, '1, '1, 1'b0));
        // Tiny denominator saturates the magnitude.
        send_face(face_word(0, FACE_ZN_LO, NBR_MAX, '1, 1, 0, 0, 1'b1));
        drain();

        // Directed 3D cases at maximum viscosity and offset OFFSET_MAX.
        apply_settings(1'b1, '1, OFFSET_MAX);
        for (int f = 0; f < 6; f++)
            send_face(face_word(CELL_MAX, 3'(f), NBR_MAX, '1, '1, 1, 0, f == 5));
        send_face(face_word(3, FACE_UNUSED_LO, 4, ONE_Q24, ONE_Q24, ONE_Q24, ONE_Q24, 1'b1));
        send_face(face_word(3, FACE_YN_HI, 4, ONE_Q24, 0, ONE_Q24, 0, 1'b1));
        drain();

        // Random phases, each under its own register settings.
        for (int p = 0; p < PHASES; p++) begin
            td = p[0];
            case (p)
                1:
                begin
                    visc = '1;
                    off  = OFFSET_MAX;
                end
                2:
                begin
                    visc = '0;
                    off  = '0;
                end
                3:
                begin
                    visc = ONE_Q24;
                    off  = OFFSET_W'($urandom_range(0, OFFSET_MAX));
                end
                default:
                begin
                    visc = ($urandom_range(0, 1) != 0) ? $urandom
                                                       : $urandom_range(32'h0010_0000,
                                                                        32'h1000_0000);
                    off  = OFFSET_W'($urandom_range(0, OFFSET_MAX));
                end
            endcase
            src_jitter  = (p != PHASES - 1);
            sink_jitter = (p != PHASES - 1);
            apply_settings(td, visc, off);
            if (p == 3)
                hold_request = 1'b1;

            // Mostly complete cells; the rest are single faces with any code and flag.
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target) begin
                if ($urandom_range(0, 4) != 0) begin
                    send_random_cell();
                end
                else begin
                    w = face_word(INDEX_BITS'($urandom_range(0, CELL_MAX)),
                                  3'($urandom_range(0, 7)),
                                  (INDEX_BITS+1)'($urandom_range(0, NBR_MAX)),
                                  pick_width(), pick_width(), pick_width(), pick_width(),
                                  1'($urandom_range(0, 1)));
                    send_face(w);
                end
            end
            drain();
        end

        // Let any stray words show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && entries_pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[sim.f]
design/fvdsa_pkg.sv
design/fvdsa_divider.sv
design/fv_diffusion_stencil_assembler_top.sv
verif/fvdsa_stencil_checker.sv
verif/tb.sv
